// ===== rtl/core/mpau_pkg.sv =====
// Shared types and constants for the max pool / argmax / unpool block.
package mpau_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_POOL    = 8;
   localparam int SAMPLE_BITS = 16;
   localparam int STORE_DEPTH = MAX_WIDTH / 2;
   localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
   localparam int COL_BITS    = $clog2(MAX_WIDTH);
   localparam int OFS_BITS    = $clog2(MAX_POOL);
   localparam int CODE_BITS   = 9;
   localparam int POOL_BITS   = 4;
   localparam int WIDTH_BITS  = 11;
   localparam int CSR_IDX_BITS = 2;

   localparam logic [CSR_IDX_BITS-1:0] CSR_DIRECTION   = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_POOL_SIZE   = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PLANE_WIDTH = 2'd2;

   localparam logic DIR_ENCODE = 1'b0;
   localparam logic DIR_DECODE = 1'b1;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic [CODE_BITS-1:0]          x_code_in;
      logic [CODE_BITS-1:0]          y_code_in;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] value;
      logic [CODE_BITS-1:0]          x_code_out;
      logic [CODE_BITS-1:0]          y_code_out;
      logic [OFS_BITS-1:0]           offset_x;
      logic [OFS_BITS-1:0]           offset_y;
      logic                          last;
   } rsp_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] max_val;
      logic [OFS_BITS-1:0]           ax;
      logic [OFS_BITS-1:0]           ay;
   } entry_type;

   // ceil(idx*256/(P-1)), indexed by {P-1, idx}
   localparam logic [CODE_BITS-1:0] ENC_CODE [64] = '{
      9'd0, 9'd0,   9'd0,   9'd0,   9'd0,   9'd0,   9'd0,   9'd0,
      9'd0, 9'd256, 9'd0,   9'd0,   9'd0,   9'd0,   9'd0,   9'd0,
      9'd0, 9'd128, 9'd256, 9'd0,   9'd0,   9'd0,   9'd0,   9'd0,
      9'd0, 9'd86,  9'd171, 9'd256, 9'd0,   9'd0,   9'd0,   9'd0,
      9'd0, 9'd64,  9'd128, 9'd192, 9'd256, 9'd0,   9'd0,   9'd0,
      9'd0, 9'd52,  9'd103, 9'd154, 9'd205, 9'd256, 9'd0,   9'd0,
      9'd0, 9'd43,  9'd86,  9'd128, 9'd171, 9'd214, 9'd256, 9'd0,
      9'd0, 9'd37,  9'd74,  9'd110, 9'd147, 9'd183, 9'd220, 9'd256
   };

endpackage

// ===== rtl/core/max_pool_argmax_unpool.sv =====
// Encode: the completing sample is registered in s1, then its result once the output is free.
// Throughput: encode takes one sample per cycle unless a block result is stalled;
//   the line-store RAM read is bypassed from the pending write on the same block.
// Decode: P*P result beats, one per cycle unless stalled; next item only after the last.
// Reset clears control and counters; the line store is not cleared (no sweep),
//   every entry is written at its block's first sample before its contents are used.
module max_pool_argmax_unpool (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  mpau_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output mpau_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mpau_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [mpau_pkg::WIDTH_BITS-1:0]     csr_data
);

   typedef enum logic [1:0] {ST_IDLE, ST_ENC, ST_DEC} state_type;

   localparam int OB = mpau_pkg::OFS_BITS;
   localparam int AB = mpau_pkg::ADDR_BITS;
   localparam int CB = mpau_pkg::COL_BITS;
   localparam int WB = mpau_pkg::WIDTH_BITS;
   localparam int PB = mpau_pkg::POOL_BITS;
   localparam int KB = mpau_pkg::CODE_BITS;

   state_type state_ff;

   logic          direction_ff;
   logic [PB-1:0] pool_size_ff;
   logic [WB-1:0] plane_width_ff;

   logic [CB-1:0] col_ff;
   logic [OB-1:0] dx_ff;
   logic [OB-1:0] dy_ff;
   logic [AB-1:0] blk_ff;

   logic                                   s1_first_ff;
   logic                                   s1_done_ff;
   logic [OB-1:0]                          s1_dx_ff;
   logic [OB-1:0]                          s1_dy_ff;
   logic [AB-1:0]                          s1_blk_ff;
   logic signed [mpau_pkg::SAMPLE_BITS-1:0] s1_sample_ff;

   mpau_pkg::entry_type line_mem [mpau_pkg::STORE_DEPTH];
   mpau_pkg::entry_type rd_q_ff;
   mpau_pkg::entry_type byp_data_ff;
   logic                byp_ff;

   logic [OB-1:0]                           ox_ff;
   logic [OB-1:0]                           oy_ff;
   logic [OB-1:0]                           xm_ff;
   logic [OB-1:0]                           ym_ff;
   logic signed [mpau_pkg::SAMPLE_BITS-1:0] dval_ff;

   logic              rsp_valid_ff;
   mpau_pkg::rsp_type rsp_data_ff;

   logic [PB-1:0] p_eff;
   logic [OB-1:0] pm1;
   logic [WB-1:0] w_eff;
   logic          rsp_free;
   logic          enc_go;
   logic          req_acc;
   logic          csr_acc;
   logic          cfg_hit;
   logic          first_in;
   logic          done_in;
   logic          last_col;
   mpau_pkg::entry_type cur_ent;
   mpau_pkg::entry_type new_ent;
   logic          dec_last;
   logic [OB-1:0] xm_in;
   logic [OB-1:0] ym_in;

   function automatic logic [OB-1:0] decode_pos(input logic [KB-1:0] code,
                                                input logic [OB-1:0] m1);
      logic [KB+OB-1:0] prod;
      logic [OB:0]      d;
      prod = code * m1;
      d    = prod[KB+OB-1:KB-1];
      return (d > {1'b0, m1}) ? m1 : d[OB-1:0];
   endfunction

   always_comb begin
      priority if (pool_size_ff < PB'(2)) begin
         p_eff = PB'(2);
      end else if (pool_size_ff > PB'(mpau_pkg::MAX_POOL)) begin
         p_eff = PB'(mpau_pkg::MAX_POOL);
      end else begin
         p_eff = pool_size_ff;
      end
      priority if (plane_width_ff < WB'(2)) begin
         w_eff = WB'(2);
      end else if (plane_width_ff > WB'(mpau_pkg::MAX_WIDTH)) begin
         w_eff = WB'(mpau_pkg::MAX_WIDTH);
      end else begin
         w_eff = plane_width_ff;
      end
   end

   assign pm1       = OB'(p_eff - PB'(1));
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign enc_go    = (state_ff == ST_ENC) && (!s1_done_ff || rsp_free);
   assign req_ready = (state_ff == ST_IDLE) || enc_go;
   assign req_acc   = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign csr_acc   = csr_valid && csr_ready;
   assign cfg_hit   = csr_acc && (csr_index == mpau_pkg::CSR_DIRECTION ||
                                  csr_index == mpau_pkg::CSR_POOL_SIZE ||
                                  csr_index == mpau_pkg::CSR_PLANE_WIDTH);

   assign first_in = (dy_ff == '0) && (dx_ff == '0);
   assign last_col = (WB'(col_ff) + WB'(1)) == w_eff;
   assign done_in  = (dy_ff == pm1) && ((dx_ff == pm1) || last_col);

   assign cur_ent = byp_ff ? byp_data_ff : rd_q_ff;

   always_comb begin
      new_ent = cur_ent;
      priority if (s1_first_ff) begin
         new_ent = '{max_val: s1_sample_ff, ax: '0, ay: '0};
      end else if (s1_sample_ff > cur_ent.max_val) begin
         new_ent = '{max_val: s1_sample_ff, ax: s1_dx_ff, ay: s1_dy_ff};
      end
   end

   assign xm_in    = decode_pos(req_data.x_code_in, pm1);
   assign ym_in    = decode_pos(req_data.y_code_in, pm1);
   assign dec_last = (ox_ff == pm1) && (oy_ff == pm1);

   // line store: one read, one write per cycle
   always_ff @(posedge clock) begin
      if (enc_go) begin
         line_mem[s1_blk_ff] <= new_ent;
      end
      if (req_acc && direction_ff == mpau_pkg::DIR_ENCODE) begin
         rd_q_ff     <= line_mem[blk_ff];
         byp_data_ff <= new_ent;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         direction_ff   <= mpau_pkg::DIR_ENCODE;
         pool_size_ff   <= PB'(2);
         plane_width_ff <= WB'(64);
         col_ff         <= '0;
         dx_ff          <= '0;
         dy_ff          <= '0;
         blk_ff         <= '0;
         byp_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (enc_go) begin
            state_ff <= ST_IDLE;
            if (s1_done_ff) begin
               rsp_valid_ff <= 1'b1;
               rsp_data_ff  <= '{value: new_ent.max_val,
                                 x_code_out: mpau_pkg::ENC_CODE[{pm1, new_ent.ax}],
                                 y_code_out: mpau_pkg::ENC_CODE[{pm1, new_ent.ay}],
                                 offset_x: '0, offset_y: '0, last: 1'b1};
            end
         end

         if (state_ff == ST_DEC && rsp_free) begin
            rsp_valid_ff <= 1'b1;
            rsp_data_ff  <= '{value: (ox_ff == xm_ff && oy_ff == ym_ff) ? dval_ff : '0,
                              x_code_out: '0, y_code_out: '0,
                              offset_x: ox_ff, offset_y: oy_ff, last: dec_last};
            if (ox_ff == pm1) begin
               ox_ff <= '0;
               oy_ff <= oy_ff + OB'(1);
            end else begin
               ox_ff <= ox_ff + OB'(1);
            end
            if (dec_last) begin
               state_ff <= ST_IDLE;
            end
         end

         if (req_acc) begin
            if (direction_ff == mpau_pkg::DIR_DECODE) begin
               state_ff <= ST_DEC;
               ox_ff    <= '0;
               oy_ff    <= '0;
               xm_ff    <= xm_in;
               ym_ff    <= ym_in;
               dval_ff  <= req_data.sample;
            end else begin
               state_ff     <= ST_ENC;
               s1_first_ff  <= first_in;
               s1_done_ff   <= done_in;
               s1_dx_ff     <= dx_ff;
               s1_dy_ff     <= dy_ff;
               s1_blk_ff    <= blk_ff;
               s1_sample_ff <= req_data.sample;
               byp_ff       <= enc_go && (s1_blk_ff == blk_ff);
               if (last_col) begin
                  col_ff <= '0;
                  dx_ff  <= '0;
                  blk_ff <= '0;
                  dy_ff  <= (dy_ff == pm1) ? '0 : dy_ff + OB'(1);
               end else begin
                  col_ff <= col_ff + CB'(1);
                  if (dx_ff == pm1) begin
                     dx_ff  <= '0;
                     blk_ff <= blk_ff + AB'(1);
                  end else begin
                     dx_ff <= dx_ff + OB'(1);
                  end
               end
            end
         end

         if (cfg_hit) begin
            unique case (csr_index)
               mpau_pkg::CSR_DIRECTION:   direction_ff   <= csr_data[0];
               mpau_pkg::CSR_POOL_SIZE:   pool_size_ff   <= csr_data[PB-1:0];
               mpau_pkg::CSR_PLANE_WIDTH: plane_width_ff <= csr_data;
               default:                   direction_ff   <= direction_ff;
            endcase
            col_ff <= '0;
            dx_ff  <= '0;
            dy_ff  <= '0;
            blk_ff <= '0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> (state_ff == ST_ENC || state_ff == ST_DEC))
      else $error("accepted beat did not start work");

   a_dec_no_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DEC) |-> !req_ready)
      else $error("input taken during unpool run");

   a_pos_in_block: assert property (@(posedge clock) disable iff (reset)
      (dx_ff <= pm1) && (dy_ff <= pm1))
      else $error("block position out of range");

   a_bypass_same_col: assert property (@(posedge clock) disable iff (reset)
      (req_acc && enc_go && direction_ff == mpau_pkg::DIR_ENCODE &&
       s1_blk_ff == blk_ff) |=> byp_ff)
      else $error("missing line store bypass");
`endif

endmodule

// ===== bench/tb_max_pool_argmax_unpool.sv =====
// Self-checking testbench for max_pool_argmax_unpool: encode and decode against a predictor.
module tb_max_pool_argmax_unpool;
   import mpau_pkg::*;

   localparam int IDLE_LIMIT    = 4000;
   localparam int SETTLE_CYCLES = 4;
   localparam int RANDOM_BEATS  = 360;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RESERVED = 2'd3;

   typedef enum logic [1:0] {
      FLOW_OPEN, FLOW_COIN, FLOW_SPARSE, FLOW_CADENCE
   } flow_mode_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   req_type                 req_data = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   rsp_type                 rsp_data;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [WIDTH_BITS-1:0]   csr_data = '0;

   max_pool_argmax_unpool dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #10 clock = ~clock;

   // predictor state
   logic                          dir_cfg;
   logic [POOL_BITS-1:0]          pool_cfg;
   logic [WIDTH_BITS-1:0]         width_cfg;
   int unsigned                   col_pos;
   int unsigned                   row_pos;
   logic signed [SAMPLE_BITS-1:0] max_line [STORE_DEPTH];
   logic [OFS_BITS-1:0]           ax_line [STORE_DEPTH];
   logic [OFS_BITS-1:0]           ay_line [STORE_DEPTH];

   req_type       samples_to_send[$];
   rsp_type       cells_due[$];
   int            beats_pushed = 0;
   int            beats_taken = 0;
   int            cells_seen = 0;
   int            mismatches = 0;
   int            csr_writes = 0;
   int            idle_cycles = 0;
   logic          req_taken = 1'b0;
   int            burst_left = 1;
   int            gap_left = 0;
   flow_mode_type stall_mode = FLOW_OPEN;
   int            stall_left = 0;
   int            cadence_step = 0;

   function automatic int unsigned pool_eff(logic [POOL_BITS-1:0] p);
      if (p < 2) return 2;
      if (p > MAX_POOL) return MAX_POOL;
      return p;
   endfunction

   function automatic int unsigned width_eff(logic [WIDTH_BITS-1:0] w);
      if (w < 2) return 2;
      if (w > MAX_WIDTH) return MAX_WIDTH;
      return w;
   endfunction

   function automatic logic [CODE_BITS-1:0] pos_to_code(int unsigned idx, int unsigned p);
      return CODE_BITS'((idx * 256 + p - 2) / (p - 1));
   endfunction

   function automatic int unsigned code_to_pos(logic [CODE_BITS-1:0] code, int unsigned p);
      int unsigned d;
      d = (code * (p - 1)) >> 8;
      return (d > p - 1) ? p - 1 : d;
   endfunction

   task automatic apply_csr(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [WIDTH_BITS-1:0] val);
      case (idx)
         CSR_DIRECTION:   dir_cfg = val[0];
         CSR_POOL_SIZE:   pool_cfg = val[POOL_BITS-1:0];
         CSR_PLANE_WIDTH: width_cfg = val;
         default:         return;
      endcase
      col_pos = 0;
      row_pos = 0;
   endtask

   task automatic pool_or_unpool(input req_type item);
      int unsigned p, w, c, blk, dx, dy, xm, ym, x, y;
      rsp_type rsp_item;
      p = pool_eff(pool_cfg);
      if (dir_cfg == DIR_DECODE) begin
         xm = code_to_pos(item.x_code_in, p);
         ym = code_to_pos(item.y_code_in, p);
         for (y = 0; y < p; y++) begin
            for (x = 0; x < p; x++) begin
               rsp_item = '0;
               if (x == xm && y == ym) rsp_item.value = item.sample;
               rsp_item.offset_x = OFS_BITS'(x);
               rsp_item.offset_y = OFS_BITS'(y);
               rsp_item.last = (x == p - 1 && y == p - 1);
               cells_due = {cells_due, rsp_item};
            end
         end
      end else begin
         w = width_eff(width_cfg);
         if (col_pos >= w) col_pos = 0;
         if (row_pos >= p) row_pos = 0;
         c = col_pos;
         blk = c / p;
         dx = c % p;
         dy = row_pos;
         if (blk >= STORE_DEPTH) blk = STORE_DEPTH - 1;
         if (dx == 0 && dy == 0) begin
            max_line[blk] = item.sample;
            ax_line[blk] = '0;
            ay_line[blk] = '0;
         end else if (item.sample > max_line[blk]) begin
            max_line[blk] = item.sample;
            ax_line[blk] = OFS_BITS'(dx);
            ay_line[blk] = OFS_BITS'(dy);
         end
         if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = (dy + 1 >= p) ? 0 : dy + 1;
         end else begin
            col_pos = c + 1;
         end
         if (dy == p - 1 && (dx == p - 1 || c == w - 1)) begin
            rsp_item = '0;
            rsp_item.value = max_line[blk];
            rsp_item.x_code_out = pos_to_code(ax_line[blk], p);
            rsp_item.y_code_out = pos_to_code(ay_line[blk], p);
            rsp_item.last = 1'b1;
            cells_due = {cells_due, rsp_item};
         end
      end
   endtask

   function automatic logic [SAMPLE_BITS-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0:       return 16'sh7fff;
         1:       return 16'sh8000;
         2, 3:    return SAMPLE_BITS'($urandom_range(0, 4) - 2);
         default: return SAMPLE_BITS'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic logic [CODE_BITS-1:0] pick_code();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return 9'd256;
         2:       return CODE_BITS'($urandom_range(257, 511));
         default: return CODE_BITS'($urandom_range(0, 256));
      endcase
   endfunction

   task automatic queue_item(input logic [SAMPLE_BITS-1:0] s,
                             input logic [CODE_BITS-1:0] xc,
                             input logic [CODE_BITS-1:0] yc);
      req_type item;
      item.sample = s;
      item.x_code_in = xc;
      item.y_code_in = yc;
      samples_to_send = {samples_to_send, item};
      beats_pushed++;
   endtask

   task automatic write_csr(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [WIDTH_BITS-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      while (beats_taken != beats_pushed || cells_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // req side: bursts with random gaps
   always @(negedge clock) begin : sender
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (samples_to_send.size() != 0) begin
            req_data <= samples_to_send.pop_front();
            req_valid <= 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 40);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // rsp side: stall mode is redrawn at random when its countdown runs out
   always @(negedge clock) begin : receiver
      if (stall_left <= 0) begin
         stall_mode = flow_mode_type'($urandom_range(0, 3));
         stall_left = $urandom_range(16, 160);
      end
      stall_left--;
      cadence_step++;
      case (stall_mode)
         FLOW_OPEN:   rsp_ready <= 1'b1;
         FLOW_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
         FLOW_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
         default:     rsp_ready <= (cadence_step % 7) < 4;
      endcase
   end

   always @(posedge clock) begin : monitor
      logic    any_beat;
      rsp_type want;
      req_taken <= req_valid && req_ready && !reset;
      any_beat = 1'b0;
      if (!reset) begin
         if (req_valid && req_ready) begin
            pool_or_unpool(req_data);
            beats_taken++;
            any_beat = 1'b1;
         end
         if (csr_valid && csr_ready) begin
            apply_csr(csr_index, csr_data);
            csr_writes++;
            any_beat = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            any_beat = 1'b1;
            cells_seen++;
            if (cells_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected rsp beat %0d: value %0d codes %0d,%0d %0s %0d,%0d %0b",
                           cells_seen, rsp_data.value, rsp_data.x_code_out,
                           rsp_data.y_code_out, "ofs", rsp_data.offset_x,
                           rsp_data.offset_y, rsp_data.last);
            end else begin
               want = cells_due.pop_front();
               if (rsp_data.value !== want.value || rsp_data.x_code_out !== want.x_code_out ||
                   rsp_data.y_code_out !== want.y_code_out ||
                   rsp_data.offset_x !== want.offset_x ||
                   rsp_data.offset_y !== want.offset_y || rsp_data.last !== want.last) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("rsp beat %0d mismatch (value codes ofs last):", cells_seen);
                     $display("   want %0d %0d,%0d %0d,%0d %0b", want.value, want.x_code_out,
                              want.y_code_out, want.offset_x, want.offset_y, want.last);
                     $display("   got  %0d %0d,%0d %0d,%0d %0b", rsp_data.value,
                              rsp_data.x_code_out, rsp_data.y_code_out, rsp_data.offset_x,
                              rsp_data.offset_y, rsp_data.last);
                  end
               end
            end
         end
         idle_cycles = any_beat ? 0 : idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                     IDLE_LIMIT, cells_due.size());
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int   pool_val, width_val, p, w, rows, n, split, random_beats, i;
      logic paused;
      dir_cfg = DIR_ENCODE;
      pool_cfg = 4'd2;
      width_cfg = 11'd64;
      col_pos = 0;
      row_pos = 0;
      random_beats = 0;
      paused = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // 2x2 blocks: tie at positive full scale, then max in the far corner
      write_csr(CSR_DIRECTION, DIR_ENCODE);
      write_csr(CSR_POOL_SIZE, 11'd2);
      write_csr(CSR_PLANE_WIDTH, 11'd4);
      queue_item(16'sh7fff, 9'd511, 9'd0);
      queue_item(16'sh7fff, 9'd0, 9'd511);
      queue_item(16'sh8000, 9'd511, 9'd511);
      queue_item(16'sh8000, 9'd0, 9'd0);
      queue_item(16'sh7fff, 9'd256, 9'd256);
      queue_item(16'sh0000, 9'd1, 9'd1);
      queue_item(16'sh8000, 9'd511, 9'd0);
      queue_item(16'shffff, 9'd0, 9'd511);
      wait_idle();

      // width not a multiple of pool: narrow last block column
      write_csr(CSR_PLANE_WIDTH, 11'd3);
      queue_item(16'sd5, 9'd0, 9'd0);
      queue_item(16'sd9, 9'd0, 9'd0);
      queue_item(16'sd7, 9'd0, 9'd0);
      queue_item(16'sd9, 9'd0, 9'd0);
      queue_item(16'sd1, 9'd0, 9'd0);
      queue_item(16'sd8, 9'd0, 9'd0);
      wait_idle();

      // decode, pool above range clamps to the largest block, codes past 256 clamp
      write_csr(CSR_DIRECTION, DIR_DECODE);
      write_csr(CSR_POOL_SIZE, 11'd15);
      queue_item(16'sh7fff, 9'd0, 9'd0);
      queue_item(16'sh8000, 9'd511, 9'd256);
      wait_idle();
      write_csr(CSR_POOL_SIZE, 11'd0);
      queue_item(16'shffff, 9'd256, 9'd128);
      wait_idle();

      // encode with pool and width below range
      write_csr(CSR_DIRECTION, DIR_ENCODE);
      write_csr(CSR_POOL_SIZE, 11'd1);
      write_csr(CSR_PLANE_WIDTH, 11'd0);
      queue_item(16'sd1, 9'd0, 9'd0);
      queue_item(16'sd2, 9'd0, 9'd0);
      queue_item(16'sd3, 9'd0, 9'd0);
      queue_item(16'sd4, 9'd0, 9'd0);
      wait_idle();

      while (random_beats < RANDOM_BEATS) begin
         pool_val = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                : $urandom_range(2, 8);
         p = pool_eff(POOL_BITS'(pool_val));
         if ($urandom_range(0, 9) < 7) begin
            width_val = p * $urandom_range(1, p > 4 ? 2 : 4);
            if ($urandom_range(0, 2) == 0) width_val += $urandom_range(1, p - 1);
            if ($urandom_range(0, 11) == 0) width_val = $urandom_range(0, 1);
            write_csr(CSR_DIRECTION, DIR_ENCODE);
            write_csr(CSR_POOL_SIZE, WIDTH_BITS'(pool_val));
            write_csr(CSR_PLANE_WIDTH, WIDTH_BITS'(width_val));
            w = width_eff(WIDTH_BITS'(width_val));
            rows = $urandom_range(1, p <= 3 ? 3 : 1);
            n = w * p * rows;
            if ($urandom_range(0, 3) == 0) n += $urandom_range(1, w);
            if (random_beats + n > RANDOM_BEATS) n = RANDOM_BEATS - random_beats + 1;
            split = (!paused || $urandom_range(0, 5) == 0) ? $urandom_range(1, n - 1) : n;
            for (i = 0; i < n; i++) begin
               if (i == split) begin
                  // hold off part way through the run until all results are in; reserved index keeps position
                  wait_idle();
                  write_csr(CSR_RESERVED, WIDTH_BITS'($urandom_range(0, 2047)));
                  paused = 1'b1;
               end
               queue_item(pick_sample(), CODE_BITS'($urandom_range(0, 511)),
                          CODE_BITS'($urandom_range(0, 511)));
            end
         end else begin
            write_csr(CSR_DIRECTION, DIR_DECODE);
            write_csr(CSR_POOL_SIZE, WIDTH_BITS'(pool_val));
            if ($urandom_range(0, 1) == 1)
               write_csr(CSR_PLANE_WIDTH, WIDTH_BITS'($urandom_range(0, 2047)));
            n = $urandom_range(2, 6);
            for (i = 0; i < n; i++) queue_item(pick_sample(), pick_code(), pick_code());
         end
         random_beats += n;
         wait_idle();
      end

      $display("Run covered %0d request beats and %0d response beats, %0d register writes,",
               beats_taken, cells_seen, csr_writes);
      $display("encode and decode over clamped pool and width settings and stalled outputs.");
      if (mismatches == 0 && cells_due.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches, %0d results outstanding", mismatches, cells_due.size());
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
